### design/abnp_pkg.sv
// Shared types and constants for the auto-base number parser.
package abnp_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int OUT_BITS       = 32;
	localparam int EXT_BITS       = 64;

	typedef enum logic [2:0] {
		PH_BLANKS   = 3'd0,
		PH_SIGNED   = 3'd1,
		PH_ZERO     = 3'd2,
		PH_HEXSTART = 3'd3,
		PH_DIGITS   = 3'd4,
		PH_ERROR    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	// parser control state, excluding the accumulator
	typedef struct packed {
		phase_t phase;
		radix_t radix;
		logic   negative;
	} ctl_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

	localparam ctl_t CTL_RESET = '{phase: PH_BLANKS, radix: RADIX_DEC, negative: 1'b0};

endpackage

### design/abnp_step.sv
// One-character state update and end-of-string result of the number parser.
module abnp_step #(
	parameter int VALUE_BITS = abnp_pkg::VALUE_BITS_DEF
) (
	input  logic [7:0]                     ch,
	input  abnp_pkg::ctl_t                 ctl,
	input  logic [VALUE_BITS-1:0]          acc,
	output abnp_pkg::ctl_t                 ctl_nxt,
	output logic [VALUE_BITS-1:0]          acc_nxt,
	output logic                           is_end,
	output logic [abnp_pkg::OUT_BITS-1:0]  res_value,
	output logic                           res_ok
);

	abnp_pkg::radix_t        eff_radix;
	logic [7:0]              dsub;
	logic [3:0]              dval;
	logic                    dok;
	logic [VALUE_BITS-1:0]   acc_mul;
	logic [VALUE_BITS-1:0]   acc_dig;
	logic [VALUE_BITS-1:0]   acc_sgn;
	logic [abnp_pkg::EXT_BITS-1:0] acc_ext;
	logic                    is_blank;
	logic                    is_x;

	assign is_end   = (ch == abnp_pkg::CH_NUL);
	assign is_blank = (ch == abnp_pkg::CH_SPACE) || (ch == abnp_pkg::CH_TAB);
	assign is_x     = (ch == abnp_pkg::CH_X_LO) || (ch == abnp_pkg::CH_X_UP);

	// radix a digit would be taken in from the current phase
	always_comb begin
		unique case (ctl.phase)
			abnp_pkg::PH_BLANKS, abnp_pkg::PH_SIGNED: eff_radix = abnp_pkg::RADIX_DEC;
			abnp_pkg::PH_ZERO:                        eff_radix = abnp_pkg::RADIX_OCT;
			default:                                  eff_radix = ctl.radix;
		endcase
	end

	always_comb begin
		dsub = ch - abnp_pkg::CH_ZERO;
		dok  = 1'b0;
		unique case (eff_radix)
			abnp_pkg::RADIX_OCT: begin
				dok = (ch >= abnp_pkg::CH_ZERO) && (ch <= abnp_pkg::CH_SEVEN);
			end
			abnp_pkg::RADIX_HEX: begin
				if ((ch >= abnp_pkg::CH_ZERO) && (ch <= abnp_pkg::CH_NINE)) begin
					dok = 1'b1;
				end else if ((ch >= abnp_pkg::CH_A_LO) && (ch <= abnp_pkg::CH_F_LO)) begin
					dok  = 1'b1;
					dsub = ch - abnp_pkg::CH_A_LO + abnp_pkg::HEX_ALPHA_OFS;
				end else if ((ch >= abnp_pkg::CH_A_UP) && (ch <= abnp_pkg::CH_F_UP)) begin
					dok  = 1'b1;
					dsub = ch - abnp_pkg::CH_A_UP + abnp_pkg::HEX_ALPHA_OFS;
				end
			end
			default: begin
				dok = (ch >= abnp_pkg::CH_ZERO) && (ch <= abnp_pkg::CH_NINE);
			end
		endcase
		dval = dsub[3:0];
	end

	// times 8, 16 or 10 (8 + 2), wrapping at the accumulator width
	always_comb begin
		unique case (eff_radix)
			abnp_pkg::RADIX_OCT: acc_mul = acc << 3;
			abnp_pkg::RADIX_HEX: acc_mul = acc << 4;
			default:             acc_mul = (acc << 3) + (acc << 1);
		endcase
		acc_dig = acc_mul + VALUE_BITS'(dval);
	end

	always_comb begin
		ctl_nxt = ctl;
		acc_nxt = acc;
		if (is_end) begin
			ctl_nxt = abnp_pkg::CTL_RESET;
			acc_nxt = '0;
		end else begin
			unique case (ctl.phase)
				abnp_pkg::PH_BLANKS: begin
					if (is_blank) begin
						ctl_nxt = ctl;
					end else if (ch == abnp_pkg::CH_MINUS) begin
						ctl_nxt.negative = 1'b1;
						ctl_nxt.phase    = abnp_pkg::PH_SIGNED;
					end else if (ch == abnp_pkg::CH_ZERO) begin
						ctl_nxt.phase = abnp_pkg::PH_ZERO;
					end else begin
						ctl_nxt.radix = abnp_pkg::RADIX_DEC;
						ctl_nxt.phase = dok ? abnp_pkg::PH_DIGITS : abnp_pkg::PH_ERROR;
						if (dok) acc_nxt = acc_dig;
					end
				end
				abnp_pkg::PH_SIGNED: begin
					if (ch == abnp_pkg::CH_ZERO) begin
						ctl_nxt.phase = abnp_pkg::PH_ZERO;
					end else begin
						ctl_nxt.radix = abnp_pkg::RADIX_DEC;
						ctl_nxt.phase = dok ? abnp_pkg::PH_DIGITS : abnp_pkg::PH_ERROR;
						if (dok) acc_nxt = acc_dig;
					end
				end
				abnp_pkg::PH_ZERO: begin
					if (is_x) begin
						ctl_nxt.radix = abnp_pkg::RADIX_HEX;
						ctl_nxt.phase = abnp_pkg::PH_HEXSTART;
					end else begin
						ctl_nxt.radix = abnp_pkg::RADIX_OCT;
						ctl_nxt.phase = dok ? abnp_pkg::PH_DIGITS : abnp_pkg::PH_ERROR;
						if (dok) acc_nxt = acc_dig;
					end
				end
				abnp_pkg::PH_HEXSTART, abnp_pkg::PH_DIGITS: begin
					ctl_nxt.phase = dok ? abnp_pkg::PH_DIGITS : abnp_pkg::PH_ERROR;
					if (dok) acc_nxt = acc_dig;
				end
				default: begin
					ctl_nxt.phase = abnp_pkg::PH_ERROR;
				end
			endcase
		end
	end

	// end-of-string result; failure forces zero
	always_comb begin
		res_ok  = (ctl.phase == abnp_pkg::PH_ZERO) || (ctl.phase == abnp_pkg::PH_DIGITS);
		acc_sgn = ctl.negative ? (~acc + VALUE_BITS'(1)) : acc;
		acc_ext = abnp_pkg::EXT_BITS'(acc_sgn);
		res_value = res_ok ? acc_ext[abnp_pkg::OUT_BITS-1:0] : '0;
	end

endmodule

### design/auto_base_number_parser_unit.sv
// Top level of the auto-base number parser: input register, parser state, result register.
//
// channel | direction | payload          | handshake
// in      | input     | char_code[7:0]   | in_valid / in_stall
// out     | output    | value[31:0], ok  | out_valid / out_stall
//
// One character is taken every cycle unless a NUL waits on a held result; the parser state updates in a single step.
// A NUL's result passes through the input register and then the result register; a held result can delay it.
// arst_n clears the parser state and both valid flags.
// A held result stalls only a following NUL; other characters keep flowing.
module auto_base_number_parser_unit #(
	parameter int VALUE_BITS = abnp_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value,
	output logic        ok
);

	logic                  valid_s1;
	logic [7:0]            char_s1;
	abnp_pkg::ctl_t        ctl_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  out_valid_q;
	logic [31:0]           value_q;
	logic                  ok_q;

	abnp_pkg::ctl_t        ctl_nxt;
	logic [VALUE_BITS-1:0] acc_nxt;
	logic                  is_end;
	logic [31:0]           res_value;
	logic                  res_ok;
	logic                  out_free;
	logic                  adv;
	logic                  in_xfer;

	abnp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.ch        (char_s1),
		.ctl       (ctl_q),
		.acc       (acc_q),
		.ctl_nxt   (ctl_nxt),
		.acc_nxt   (acc_nxt),
		.is_end    (is_end),
		.res_value (res_value),
		.res_ok    (res_ok)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!is_end || out_free);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) char_s1 <= char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= abnp_pkg::CTL_RESET;
			acc_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_nxt;
			acc_q <= acc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && is_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_end) begin
			value_q <= res_value;
			ok_q    <= res_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign ok        = ok_q;

	// a finished string leaves the parser in its reset state
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && is_end) |=> (ctl_q == abnp_pkg::CTL_RESET) && (acc_q == '0))
		else $error("parser state not cleared after end of string");

	// only a NUL waiting on a held result may stall the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_end && out_valid_q && out_stall))
		else $error("input stalled without a pending result");

	// an error sticks until the end of the string
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.phase == abnp_pkg::PH_ERROR && adv && !is_end)
			|=> (ctl_q.phase == abnp_pkg::PH_ERROR))
		else $error("error phase left before end of string");

	// a failed parse reports zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (value_q == '0))
		else $error("failed parse with nonzero value");

endmodule

### bench/auto_base_number_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the auto-base number parser: directed strings, a long output hold, random strings.
module auto_base_number_parser_unit_tb;

	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 800;
	localparam int TAIL_CYCLES  = 8;

	typedef struct {
		logic [31:0] value;
		logic        ok;
	} parse_result_t;

	typedef logic [7:0] text_t[$];

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PATTERN
	} stall_pattern_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        ok;

	auto_base_number_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.ok        (ok)
	);

	always #1 clk = ~clk;

	// parser state as predicted from accepted characters
	abnp_pkg::phase_t m_phase = abnp_pkg::PH_BLANKS;
	abnp_pkg::radix_t m_radix = abnp_pkg::RADIX_DEC;
	logic             m_neg   = 1'b0;
	logic [31:0]      m_acc   = '0;

	parse_result_t pending_results[$];

	int             error_count  = 0;
	int             idle_cycles  = 0;
	int             items_sent   = 0;
	int             burst_left   = 0;
	bit             gaps_on      = 1'b0;
	stall_pattern_t stall_mode   = STALL_NONE;
	int             holds_asked  = 0;
	int             holds_served = 0;
	int             hold_left    = 0;
	int             stall_tick   = 0;

	function automatic void accumulate_digit(input logic [7:0] c);
		logic [7:0]  d;
		logic [31:0] radix_mul;
		logic        good;
		good = 1'b0;
		d = '0;
		case (m_radix)
			abnp_pkg::RADIX_OCT: begin
				radix_mul = 32'd8;
				if (c >= abnp_pkg::CH_ZERO && c <= abnp_pkg::CH_SEVEN) begin
					good = 1'b1;
					d = c - abnp_pkg::CH_ZERO;
				end
			end
			abnp_pkg::RADIX_HEX: begin
				radix_mul = 32'd16;
				if (c >= abnp_pkg::CH_ZERO && c <= abnp_pkg::CH_NINE) begin
					good = 1'b1;
					d = c - abnp_pkg::CH_ZERO;
				end else if (c >= abnp_pkg::CH_A_LO && c <= abnp_pkg::CH_F_LO) begin
					good = 1'b1;
					d = c - abnp_pkg::CH_A_LO + abnp_pkg::HEX_ALPHA_OFS;
				end else if (c >= abnp_pkg::CH_A_UP && c <= abnp_pkg::CH_F_UP) begin
					good = 1'b1;
					d = c - abnp_pkg::CH_A_UP + abnp_pkg::HEX_ALPHA_OFS;
				end
			end
			default: begin
				radix_mul = 32'd10;
				if (c >= abnp_pkg::CH_ZERO && c <= abnp_pkg::CH_NINE) begin
					good = 1'b1;
					d = c - abnp_pkg::CH_ZERO;
				end
			end
		endcase
		if (good) begin
			m_acc = m_acc * radix_mul + 32'(d);
			m_phase = abnp_pkg::PH_DIGITS;
		end else begin
			m_phase = abnp_pkg::PH_ERROR;
		end
	endfunction

	// advances the predicted parser by one character; a NUL queues the result
	function automatic void parse_char(input logic [7:0] c);
		parse_result_t r;
		if (c == abnp_pkg::CH_NUL) begin
			r.ok = (m_phase == abnp_pkg::PH_ZERO || m_phase == abnp_pkg::PH_DIGITS);
			r.value = r.ok ? (m_neg ? -m_acc : m_acc) : '0;
			pending_results.push_back(r);
			m_phase = abnp_pkg::PH_BLANKS;
			m_radix = abnp_pkg::RADIX_DEC;
			m_neg = 1'b0;
			m_acc = '0;
		end else begin
			case (m_phase)
				abnp_pkg::PH_BLANKS: begin
					if (c == abnp_pkg::CH_MINUS) begin
						m_neg = 1'b1;
						m_phase = abnp_pkg::PH_SIGNED;
					end else if (c == abnp_pkg::CH_ZERO) begin
						m_phase = abnp_pkg::PH_ZERO;
					end else if (c != abnp_pkg::CH_SPACE && c != abnp_pkg::CH_TAB) begin
						m_radix = abnp_pkg::RADIX_DEC;
						accumulate_digit(c);
					end
				end
				abnp_pkg::PH_SIGNED: begin
					if (c == abnp_pkg::CH_ZERO) begin
						m_phase = abnp_pkg::PH_ZERO;
					end else begin
						m_radix = abnp_pkg::RADIX_DEC;
						accumulate_digit(c);
					end
				end
				abnp_pkg::PH_ZERO: begin
					if (c == abnp_pkg::CH_X_LO || c == abnp_pkg::CH_X_UP) begin
						m_radix = abnp_pkg::RADIX_HEX;
						m_phase = abnp_pkg::PH_HEXSTART;
					end else begin
						m_radix = abnp_pkg::RADIX_OCT;
						accumulate_digit(c);
					end
				end
				abnp_pkg::PH_HEXSTART, abnp_pkg::PH_DIGITS: accumulate_digit(c);
				default: m_phase = abnp_pkg::PH_ERROR;
			endcase
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t mismatch: %s got %h want %h", $time, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : check_result
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with none pending", value, '0);
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", 32'(ok), 32'(want.ok));
				if (value !== want.value)
					report_mismatch("value", value, want.value);
			end
		end
	end

	// output stall: a requested long hold wins over the current pattern
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (holds_served != holds_asked) begin
			holds_served <= holds_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= ((stall_tick % 7) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_char(input logic [7:0] c);
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		parse_char(c);
		items_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(abnp_pkg::CH_NUL);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly well-formed numbers in every radix; some noise and corrupted strings
	function automatic text_t random_text();
		text_t t;
		int    kind;
		int    n;
		int    v;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
			t.push_back($urandom_range(0, 1) ? abnp_pkg::CH_SPACE : abnp_pkg::CH_TAB);
		if ($urandom_range(0, 2) == 0)
			t.push_back(abnp_pkg::CH_MINUS);
		kind = $urandom_range(0, 8);
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5);
		if (kind <= 3) begin
			t.push_back(8'(abnp_pkg::CH_ZERO + $urandom_range(1, 9)));
			repeat (n) t.push_back(8'(abnp_pkg::CH_ZERO + $urandom_range(0, 9)));
		end else if (kind <= 5) begin
			t.push_back(abnp_pkg::CH_ZERO);
			repeat (n) t.push_back(8'(abnp_pkg::CH_ZERO + $urandom_range(0, 7)));
		end else if (kind <= 7) begin
			t.push_back(abnp_pkg::CH_ZERO);
			t.push_back($urandom_range(0, 1) ? abnp_pkg::CH_X_UP : abnp_pkg::CH_X_LO);
			repeat (n == 0 && $urandom_range(0, 3) != 0 ? 1 : n) begin
				v = $urandom_range(0, 15);
				t.push_back(v < 10 ? 8'(abnp_pkg::CH_ZERO + v) :
					8'(($urandom_range(0, 1) ? abnp_pkg::CH_A_UP : abnp_pkg::CH_A_LO)
						+ v - 10));
			end
		end else begin
			t.delete();
			repeat ($urandom_range(0, 6)) t.push_back(8'($urandom_range(1, 255)));
		end
		if (t.size() != 0 && $urandom_range(0, 7) == 0)
			t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(1, 255));
		return t;
	endfunction

	task automatic test_directed();
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		send_string("0");
		send_string("-0");
		send_string("0x");
		send_string("\t-");
		send_string("- 1");
		send_string("0Xaf9");
		send_string("017");
		// a good digit, then a bad digit from the high half of the byte range, so the parse fails
		send_char(abnp_pkg::CH_NINE);
		send_char(8'hFF);
		send_char(abnp_pkg::CH_NUL);
		send_string("");
		wait_drained();
	endtask

	// results back up behind a long hold until a NUL stalls the input
	task automatic test_long_holdoff();
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		holds_asked++;
		repeat (40) begin
			send_char(8'(abnp_pkg::CH_ZERO + $urandom_range(1, 9)));
			send_char(abnp_pkg::CH_NUL);
		end
		wait_drained();
	endtask

	task automatic test_random_strings(input int target);
		int    stop_at;
		int    strings;
		text_t t;
		stop_at = items_sent + target;
		strings = 0;
		while (items_sent < stop_at) begin
			if (strings % 40 == 0) begin
				stall_mode = stall_pattern_t'($urandom_range(0, 3));
				gaps_on = $urandom_range(0, 1);
			end
			t = random_text();
			foreach (t[i])
				send_char(t[i]);
			send_char(abnp_pkg::CH_NUL);
			strings++;
			if (strings % 150 == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_code = abnp_pkg::CH_NUL;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_holdoff();
		test_random_strings(RANDOM_ITEMS);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
design/abnp_pkg.sv
design/abnp_step.sv
design/auto_base_number_parser_unit.sv
bench/auto_base_number_parser_unit_tb.sv
